FILE: hdl/owm_pkg.sv
// shared types, codes and register defaults of the one-wire bit sequencer
package owm_pkg;

   localparam int CfgWidth = 10;
   localparam int CfgCount = 8;
   localparam int CfgIndexWidth = 3;
   localparam int BitsPerByte = 8;

   // command codes on the request op field
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // register indexes
   localparam logic [CfgIndexWidth-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CfgIndexWidth-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [CfgIndexWidth-1:0] REG_PRESENCE_TAIL = 3'd2;
   localparam logic [CfgIndexWidth-1:0] REG_WRITE_ONE_LOW = 3'd3;
   localparam logic [CfgIndexWidth-1:0] REG_WRITE_ZERO_LOW = 3'd4;
   localparam logic [CfgIndexWidth-1:0] REG_READ_LOW      = 3'd5;
   localparam logic [CfgIndexWidth-1:0] REG_READ_SAMPLE   = 3'd6;
   localparam logic [CfgIndexWidth-1:0] REG_SLOT_LENGTH   = 3'd7;

   localparam logic [CfgWidth-1:0] CFG_RESET [CfgCount] = '{
      10'd480, 10'd70, 10'd410, 10'd5, 10'd65, 10'd5, 10'd15, 10'd70
   };

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LOW,
      PH_WAIT,
      PH_HIGH
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_RESET = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   // one classified request beat
   typedef struct packed {
      logic       tick;
      kind_type   kind;
      logic [7:0] write_value;
      logic       line_level;
   } item_type;

   // a duration register with zero taken as one, as a signed slot-arithmetic value
   function automatic logic signed [11:0] reg_time(input logic [CfgWidth-1:0] v);
      logic signed [11:0] r;
      if (v == '0) begin
         r = 12'sd1;
      end else begin
         r = $signed({2'b00, v});
      end
      return r;
   endfunction

endpackage

FILE: hdl/owm_front.sv
// request intake: classifies beats and queues them for the sequencer
module owm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [7:0]          req_write_value,
   input  logic                req_line_level,
   output logic                item_valid,
   output owm_pkg::item_type   item,
   input  logic                item_pop
);

   localparam logic [1:0] QDepth = 2'd2;

   owm_pkg::item_type queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   owm_pkg::item_type classified;
   logic       push;
   logic       pop;

   always_comb begin
      classified.write_value = req_write_value;
      classified.line_level  = req_line_level;
      unique case (req_op)
         owm_pkg::OP_TICK: begin
            classified.tick = 1'b1;
            classified.kind = owm_pkg::KIND_NONE;
         end
         owm_pkg::OP_RESET: begin
            classified.tick = 1'b0;
            classified.kind = owm_pkg::KIND_RESET;
         end
         owm_pkg::OP_WRITE: begin
            classified.tick = 1'b0;
            classified.kind = owm_pkg::KIND_WRITE;
         end
         owm_pkg::OP_READ: begin
            classified.tick = 1'b0;
            classified.kind = owm_pkg::KIND_READ;
         end
         default: begin
            classified.tick = 1'b1;
            classified.kind = owm_pkg::KIND_NONE;
         end
      endcase
   end

   assign req_ready  = (count_ff != QDepth);
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

FILE: hdl/owm_back.sv
// slot sequencer: timing registers, phase machine and the result register
module owm_back #(
   parameter int TIMER_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [owm_pkg::CfgIndexWidth-1:0]    csr_index,
   input  logic [owm_pkg::CfgWidth-1:0]         csr_wdata,
   input  logic                                 item_valid,
   input  owm_pkg::item_type                    item,
   output logic                                 item_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_drive_low,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_byte_done,
   output logic [7:0]                           rsp_read_value,
   output logic                                 rsp_device_present,
   output logic                                 rsp_status
);

   localparam int CntWidth = (TIMER_BITS > 10) ? TIMER_BITS : 10;
   localparam logic [TIMER_BITS-1:0] TimerMax = '1;

   // clamp a slot duration into the timer: below one gives one, above the range saturates
   function automatic logic [TIMER_BITS-1:0] load_time(input logic signed [11:0] v);
      logic [CntWidth-1:0] mag;
      logic [CntWidth-1:0] tmax;
      logic [TIMER_BITS-1:0] r;
      mag  = CntWidth'(v[9:0]);
      tmax = CntWidth'(TimerMax);
      if (v < 12'sd1) begin
         r = TIMER_BITS'(1);
      end else if (mag > tmax) begin
         r = TimerMax;
      end else begin
         r = TIMER_BITS'(mag);
      end
      return r;
   endfunction

   logic [owm_pkg::CfgWidth-1:0] cfg_ff [owm_pkg::CfgCount];

   owm_pkg::phase_type    phase_ff, phase_in;
   owm_pkg::kind_type     kind_ff, kind_in;
   logic [TIMER_BITS-1:0] cnt_ff, cnt_in;
   logic [2:0]            bit_ff, bit_in;
   logic [7:0]            send_ff, send_in;
   logic [7:0]            recv_ff, recv_in;
   logic                  pres_ff, pres_in;
   logic                  drive_ff, drive_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_drive_ff, out_busy_ff, out_done_ff, out_pres_ff, out_status_ff;
   logic [7:0] out_read_ff;

   logic accept, busy, start, rejected, advance, last_slot, finish, next_slot;
   owm_pkg::kind_type  slot_kind;
   logic               next_bit;
   logic signed [11:0] t_reset_low, t_pres_wait, t_pres_tail, t_one_low, t_zero_low;
   logic signed [11:0] t_read_low, t_read_sample, t_slot;
   logic signed [11:0] wlow_cur, wlow_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < owm_pkg::CfgCount; i++) begin
            cfg_ff[i] <= owm_pkg::CFG_RESET[i];
         end
      end else if (csr_write_en) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   assign t_reset_low   = owm_pkg::reg_time(cfg_ff[owm_pkg::REG_RESET_LOW]);
   assign t_pres_wait   = owm_pkg::reg_time(cfg_ff[owm_pkg::REG_PRESENCE_WAIT]);
   assign t_pres_tail   = owm_pkg::reg_time(cfg_ff[owm_pkg::REG_PRESENCE_TAIL]);
   assign t_one_low     = owm_pkg::reg_time(cfg_ff[owm_pkg::REG_WRITE_ONE_LOW]);
   assign t_zero_low    = owm_pkg::reg_time(cfg_ff[owm_pkg::REG_WRITE_ZERO_LOW]);
   assign t_read_low    = owm_pkg::reg_time(cfg_ff[owm_pkg::REG_READ_LOW]);
   assign t_read_sample = owm_pkg::reg_time(cfg_ff[owm_pkg::REG_READ_SAMPLE]);
   assign t_slot        = owm_pkg::reg_time(cfg_ff[owm_pkg::REG_SLOT_LENGTH]);

   // a beat moves on when the result register is free or being emptied
   assign item_pop  = item_valid && (!rsp_valid_ff || rsp_ready);
   assign accept    = item_pop;
   assign busy      = (phase_ff != owm_pkg::PH_IDLE);
   assign start     = accept && !item.tick && !busy;
   assign rejected  = accept && !item.tick && busy;
   assign advance   = accept && item.tick && busy && (cnt_ff == TIMER_BITS'(1));
   assign last_slot = (kind_ff == owm_pkg::KIND_RESET) || (bit_ff == 3'(owm_pkg::BitsPerByte - 1));
   assign finish    = advance && (phase_ff == owm_pkg::PH_HIGH) && last_slot;
   assign next_slot = advance && (phase_ff == owm_pkg::PH_HIGH) && !last_slot;

   assign slot_kind = start ? item.kind : kind_ff;
   assign next_bit  = start ? item.write_value[0] : send_ff[bit_ff + 3'd1];
   assign wlow_cur  = send_ff[bit_ff] ? t_one_low : t_zero_low;
   assign wlow_next = next_bit ? t_one_low : t_zero_low;

   // next state of the phase machine
   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      bit_in   = bit_ff;
      if (start) begin
         phase_in = owm_pkg::PH_LOW;
         kind_in  = item.kind;
         bit_in   = 3'd0;
      end else if (advance) begin
         unique case (phase_ff)
            owm_pkg::PH_LOW: begin
               phase_in = (kind_ff == owm_pkg::KIND_WRITE) ? owm_pkg::PH_HIGH
                                                           : owm_pkg::PH_WAIT;
            end
            owm_pkg::PH_WAIT: begin
               phase_in = owm_pkg::PH_HIGH;
            end
            owm_pkg::PH_HIGH: begin
               if (last_slot) begin
                  phase_in = owm_pkg::PH_IDLE;
                  kind_in  = owm_pkg::KIND_NONE;
                  bit_in   = 3'd0;
               end else begin
                  phase_in = owm_pkg::PH_LOW;
                  bit_in   = bit_ff + 3'd1;
               end
            end
            owm_pkg::PH_IDLE: begin
               phase_in = owm_pkg::PH_IDLE;
            end
            default: begin
               phase_in = owm_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // timer loads, bus drive and byte datapath
   always_comb begin
      cnt_in   = cnt_ff;
      drive_in = drive_ff;
      send_in  = send_ff;
      recv_in  = recv_ff;
      pres_in  = pres_ff;
      if (accept && item.tick && busy) begin
         cnt_in = cnt_ff - TIMER_BITS'(1);
      end
      if (start) begin
         if (item.kind == owm_pkg::KIND_WRITE) begin
            send_in = item.write_value;
         end
         if (item.kind == owm_pkg::KIND_READ) begin
            recv_in = 8'd0;
         end
      end
      if (start || next_slot) begin
         drive_in = 1'b1;
         unique case (slot_kind)
            owm_pkg::KIND_RESET: cnt_in = load_time(t_reset_low);
            owm_pkg::KIND_WRITE: cnt_in = load_time(wlow_next);
            owm_pkg::KIND_READ:  cnt_in = load_time(t_read_low);
            default:             cnt_in = load_time(t_read_low);
         endcase
      end else if (finish) begin
         cnt_in   = '0;
         drive_in = 1'b0;
      end else if (advance && phase_ff == owm_pkg::PH_LOW) begin
         drive_in = 1'b0;
         unique case (kind_ff)
            owm_pkg::KIND_RESET: cnt_in = load_time(t_pres_wait);
            owm_pkg::KIND_READ:  cnt_in = load_time(t_read_sample);
            default:             cnt_in = load_time(t_slot - wlow_cur);
         endcase
      end else if (advance && phase_ff == owm_pkg::PH_WAIT) begin
         if (kind_ff == owm_pkg::KIND_RESET) begin
            // a device answers by holding the line low
            pres_in = !item.line_level;
            cnt_in  = load_time(t_pres_tail);
         end else begin
            recv_in = recv_ff | (8'(item.line_level) << bit_ff);
            cnt_in  = load_time(t_slot - t_read_low - t_read_sample);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= owm_pkg::PH_IDLE;
         kind_ff  <= owm_pkg::KIND_NONE;
         cnt_ff   <= '0;
         bit_ff   <= 3'd0;
         send_ff  <= 8'd0;
         recv_ff  <= 8'd0;
         pres_ff  <= 1'b0;
         drive_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         cnt_ff   <= cnt_in;
         bit_ff   <= bit_in;
         send_ff  <= send_in;
         recv_ff  <= recv_in;
         pres_ff  <= pres_in;
         drive_ff <= drive_in;
      end
   end

   // result register
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_drive_ff  <= drive_in;
         out_busy_ff   <= (phase_in != owm_pkg::PH_IDLE);
         out_done_ff   <= finish;
         out_read_ff   <= recv_in;
         out_pres_ff   <= pres_in;
         out_status_ff <= rejected;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_low      = out_drive_ff;
   assign rsp_busy_res       = out_busy_ff;
   assign rsp_byte_done      = out_done_ff;
   assign rsp_read_value     = out_read_ff;
   assign rsp_device_present = out_pres_ff;
   assign rsp_status         = out_status_ff;

endmodule

FILE: hdl/one_wire_master_bit_sequencer.sv
// top level of the one-wire bus master bit sequencer
//
//  channel   ports   direction  content
//  request   req_*   in         op, write byte, sampled line level
//  result    rsp_*   out        bus drive, busy, done, read byte, presence, status
//  csr       csr_*   in         write-only timing registers, indexes 0 to 7
//
// one request beat per clock while the queue has room; its result beat passes first
// through the request queue and then through the result register
// the two-entry request queue and the result register decouple the sides, so a
// stalled result only blocks intake once the queue has filled
// reset is synchronous and restores the default slot timing; no memory clearing pass
module one_wire_master_bit_sequencer #(
   parameter int TIMER_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_op,
   input  logic [7:0]                         req_write_value,
   input  logic                               req_line_level,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_drive_low,
   output logic                               rsp_busy_res,
   output logic                               rsp_byte_done,
   output logic [7:0]                         rsp_read_value,
   output logic                               rsp_device_present,
   output logic                               rsp_status,
   input  logic                               csr_write_en,
   input  logic [owm_pkg::CfgIndexWidth-1:0]  csr_index,
   input  logic [owm_pkg::CfgWidth-1:0]       csr_wdata
);

   logic              item_valid;
   logic              item_pop;
   owm_pkg::item_type item;

   owm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_write_value (req_write_value),
      .req_line_level  (req_line_level),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   owm_back #(
      .TIMER_BITS (TIMER_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_low      (rsp_drive_low),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_byte_done      (rsp_byte_done),
      .rsp_read_value     (rsp_read_value),
      .rsp_device_present (rsp_device_present),
      .rsp_status         (rsp_status)
   );

endmodule

FILE: tb/sv/tb_one_wire_master_bit_sequencer.sv
// self-checking testbench of the one-wire bus master bit sequencer
module tb_one_wire_master_bit_sequencer;

   localparam int TimerBits = 10;
   localparam int TimerMax = (1 << TimerBits) - 1;

   typedef struct {
      logic       drive_low;
      logic       busy;
      logic       done;
      logic [7:0] read_value;
      logic       present;
      logic       status;
   } bus_result_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [1:0]                        req_op;
   logic [7:0]                        req_write_value;
   logic                              req_line_level;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic                              rsp_drive_low;
   logic                              rsp_busy_res;
   logic                              rsp_byte_done;
   logic [7:0]                        rsp_read_value;
   logic                              rsp_device_present;
   logic                              rsp_status;
   logic                              csr_write_en;
   logic [owm_pkg::CfgIndexWidth-1:0] csr_index;
   logic [owm_pkg::CfgWidth-1:0]      csr_wdata;

   // predicted bus master state and its copy of the timing registers
   logic [owm_pkg::CfgWidth-1:0] timing [owm_pkg::CfgCount];
   logic [owm_pkg::CfgWidth-1:0] next_timing [owm_pkg::CfgCount];
   owm_pkg::phase_type           bus_phase;
   owm_pkg::kind_type            bus_kind;
   int                           slot_count;
   int                           bit_index;
   logic [7:0]                   tx_byte;
   logic [7:0]                   rx_byte;
   logic                         presence_seen;
   logic                         pulling_low;

   bus_result_type pending_bus_results [$];
   int             error_count = 0;
   int             send_idle_pct = 0;
   int             stall_pct = 0;
   int             hold_cycles = 0;
   int             hold_id = 0;
   int             hold_seen = 0;
   int             hold_left = 0;

   one_wire_master_bit_sequencer #(
      .TIMER_BITS(TimerBits)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_write_value(req_write_value),
      .req_line_level(req_line_level),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_drive_low(rsp_drive_low),
      .rsp_busy_res(rsp_busy_res),
      .rsp_byte_done(rsp_byte_done),
      .rsp_read_value(rsp_read_value),
      .rsp_device_present(rsp_device_present),
      .rsp_status(rsp_status),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   // zero in a duration register counts as one
   function automatic int duration(input logic [owm_pkg::CfgIndexWidth-1:0] idx);
      return (timing[idx] == '0) ? 1 : int'(timing[idx]);
   endfunction

   function automatic int clamp_duration(input int v);
      if (v < 1) return 1;
      if (v > TimerMax) return TimerMax;
      return v;
   endfunction

   function automatic int write_low_duration();
      return tx_byte[bit_index] ? duration(owm_pkg::REG_WRITE_ONE_LOW)
                                : duration(owm_pkg::REG_WRITE_ZERO_LOW);
   endfunction

   function automatic void open_slot();
      bus_phase = owm_pkg::PH_LOW;
      pulling_low = 1'b1;
      case (bus_kind)
         owm_pkg::KIND_RESET: begin
            slot_count = clamp_duration(duration(owm_pkg::REG_RESET_LOW));
         end
         owm_pkg::KIND_WRITE: begin
            slot_count = clamp_duration(write_low_duration());
         end
         default: begin
            slot_count = clamp_duration(duration(owm_pkg::REG_READ_LOW));
         end
      endcase
   endfunction

   // step to the next interval when the countdown expires; 1 when the operation is over
   function automatic bit end_of_interval(input logic line);
      if (bus_phase == owm_pkg::PH_LOW) begin
         pulling_low = 1'b0;
         if (bus_kind == owm_pkg::KIND_RESET) begin
            bus_phase = owm_pkg::PH_WAIT;
            slot_count = clamp_duration(duration(owm_pkg::REG_PRESENCE_WAIT));
         end else if (bus_kind == owm_pkg::KIND_READ) begin
            bus_phase = owm_pkg::PH_WAIT;
            slot_count = clamp_duration(duration(owm_pkg::REG_READ_SAMPLE));
         end else begin
            bus_phase = owm_pkg::PH_HIGH;
            slot_count = clamp_duration(duration(owm_pkg::REG_SLOT_LENGTH)
                                        - write_low_duration());
         end
         return 1'b0;
      end
      if (bus_phase == owm_pkg::PH_WAIT) begin
         bus_phase = owm_pkg::PH_HIGH;
         if (bus_kind == owm_pkg::KIND_RESET) begin
            presence_seen = !line;
            slot_count = clamp_duration(duration(owm_pkg::REG_PRESENCE_TAIL));
         end else begin
            if (line) rx_byte[bit_index] = 1'b1;
            slot_count = clamp_duration(duration(owm_pkg::REG_SLOT_LENGTH)
                                        - duration(owm_pkg::REG_READ_LOW)
                                        - duration(owm_pkg::REG_READ_SAMPLE));
         end
         return 1'b0;
      end
      if (bus_kind != owm_pkg::KIND_RESET && bit_index < owm_pkg::BitsPerByte - 1) begin
         bit_index++;
         open_slot();
         return 1'b0;
      end
      bus_phase = owm_pkg::PH_IDLE;
      bus_kind = owm_pkg::KIND_NONE;
      slot_count = 0;
      bit_index = 0;
      pulling_low = 1'b0;
      return 1'b1;
   endfunction

   function automatic bus_result_type advance_bus_master(input logic [1:0] op,
                                                         input logic [7:0] wv,
                                                         input logic line);
      bus_result_type r;
      r.done = 1'b0;
      r.status = 1'b0;
      if (op == owm_pkg::OP_TICK) begin
         if (bus_phase != owm_pkg::PH_IDLE) begin
            if (slot_count > 0) slot_count--;
            if (slot_count == 0) r.done = end_of_interval(line);
         end
      end else if (bus_phase != owm_pkg::PH_IDLE) begin
         r.status = 1'b1;
      end else begin
         bus_kind = owm_pkg::kind_type'(op);
         bit_index = 0;
         if (op == owm_pkg::OP_WRITE) tx_byte = wv;
         else if (op == owm_pkg::OP_READ) rx_byte = '0;
         open_slot();
      end
      r.drive_low = pulling_low;
      r.busy = (bus_phase != owm_pkg::PH_IDLE);
      r.read_value = rx_byte;
      r.present = presence_seen;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // result beats are compared against the oldest prediction
   always @(posedge clock) begin
      bus_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bus_results.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = pending_bus_results.pop_front();
            check_field("drive_low", 8'(rsp_drive_low), 8'(want.drive_low));
            check_field("busy_res", 8'(rsp_busy_res), 8'(want.busy));
            check_field("byte_done", 8'(rsp_byte_done), 8'(want.done));
            check_field("read_value", rsp_read_value, want.read_value);
            check_field("device_present", 8'(rsp_device_present), 8'(want.present));
            check_field("status", 8'(rsp_status), 8'(want.status));
         end
      end
   end

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (hold_id != hold_seen) begin
         hold_left = hold_cycles;
         hold_seen = hold_id;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_bus_item(input logic [1:0] op, input logic [7:0] wv, input logic line);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_write_value <= wv;
      req_line_level <= line;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_bus_results.push_back(advance_bus_master(op, wv, line));
   endtask

   task automatic drain_bus_results();
      req_valid <= 1'b0;
      while (pending_bus_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // writes every register from next_timing, one per cycle
   task automatic apply_timing();
      for (int i = 0; i < owm_pkg::CfgCount; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= owm_pkg::CfgIndexWidth'(i);
         csr_wdata <= next_timing[i];
         timing[i] = next_timing[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   task automatic fill_timing(input int lows, input int slot);
      for (int i = 0; i < owm_pkg::CfgCount; i++) next_timing[i] = owm_pkg::CfgWidth'(lows);
      next_timing[owm_pkg::REG_SLOT_LENGTH] = owm_pkg::CfgWidth'(slot);
   endtask

   // level below zero gives a random line on each tick
   task automatic tick_until_idle(input int level);
      while (bus_phase != owm_pkg::PH_IDLE)
         send_bus_item(owm_pkg::OP_TICK, 8'($urandom),
                       (level < 0) ? 1'($urandom) : 1'(level));
   endtask

   task automatic test_idle_and_default_timing();
      send_bus_item(owm_pkg::OP_TICK, 8'h00, 1'b0);
      send_bus_item(owm_pkg::OP_TICK, 8'hFF, 1'b1);
      send_bus_item(owm_pkg::OP_READ, 8'h00, 1'b0);
      repeat (3) send_bus_item(owm_pkg::OP_TICK, 8'h00, 1'b1);
      // busy: every command bounces
      send_bus_item(owm_pkg::OP_WRITE, 8'hFF, 1'b1);
      send_bus_item(owm_pkg::OP_RESET, 8'h00, 1'b0);
      send_bus_item(owm_pkg::OP_READ, 8'h81, 1'b1);
      drain_bus_results();
      // zero everywhere: new values apply from the next load, remainders clamp to one
      fill_timing(0, 0);
      apply_timing();
      tick_until_idle(-1);
   endtask

   task automatic test_reset_presence();
      drain_bus_results();
      fill_timing(1, 2);
      next_timing[owm_pkg::REG_RESET_LOW] = 10'd3;
      next_timing[owm_pkg::REG_PRESENCE_WAIT] = 10'd2;
      next_timing[owm_pkg::REG_PRESENCE_TAIL] = 10'd2;
      apply_timing();
      send_bus_item(owm_pkg::OP_RESET, 8'h00, 1'b0);
      send_bus_item(owm_pkg::OP_WRITE, 8'h3C, 1'b0);
      tick_until_idle(0);
      send_bus_item(owm_pkg::OP_RESET, 8'hFF, 1'b1);
      tick_until_idle(1);
   endtask

   task automatic test_write_bytes();
      drain_bus_results();
      fill_timing(1, 2);
      next_timing[owm_pkg::REG_WRITE_ONE_LOW] = 10'd3;
      apply_timing();
      send_bus_item(owm_pkg::OP_WRITE, 8'h00, 1'b1);
      tick_until_idle(-1);
      send_bus_item(owm_pkg::OP_WRITE, 8'hFF, 1'b0);
      tick_until_idle(-1);
      send_bus_item(owm_pkg::OP_WRITE, 8'hA5, 1'b1);
      tick_until_idle(-1);
   endtask

   task automatic test_read_bytes();
      drain_bus_results();
      fill_timing(1, 1);
      next_timing[owm_pkg::REG_READ_SAMPLE] = 10'd2;
      apply_timing();
      send_bus_item(owm_pkg::OP_READ, 8'h00, 1'b1);
      tick_until_idle(1);
      // read byte is cleared at the start of the next read
      send_bus_item(owm_pkg::OP_READ, 8'hFF, 1'b0);
      tick_until_idle(0);
      send_bus_item(owm_pkg::OP_READ, 8'h00, 1'b0);
      tick_until_idle(-1);
   endtask

   // a reset low time that uses the top bit of the timer
   task automatic test_long_durations();
      drain_bus_results();
      fill_timing(1, 2);
      next_timing[owm_pkg::REG_RESET_LOW] = 10'd700;
      apply_timing();
      send_bus_item(owm_pkg::OP_RESET, 8'h00, 1'b0);
      tick_until_idle(0);
   endtask

   task automatic test_result_backpressure();
      drain_bus_results();
      fill_timing(2, 6);
      apply_timing();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 60;
      hold_id++;
      send_bus_item(owm_pkg::OP_WRITE, 8'hC3, 1'b0);
      repeat (30) send_bus_item(owm_pkg::OP_TICK, 8'($urandom), 1'($urandom));
      tick_until_idle(-1);
   endtask

   task automatic run_random_traffic(input int count, input int idle_pct, input int stall);
      int         counted;
      int         pick;
      logic [1:0] op;
      counted = 0;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      while (counted < count) begin
         if (counted % 150 == 0) begin
            drain_bus_results();
            for (int i = 0; i < owm_pkg::CfgCount; i++)
               next_timing[i] = owm_pkg::CfgWidth'($urandom_range(0, 6));
            next_timing[owm_pkg::REG_SLOT_LENGTH] = owm_pkg::CfgWidth'($urandom_range(0, 14));
            if ($urandom_range(0, 3) == 0) begin
               next_timing[owm_pkg::REG_RESET_LOW] = owm_pkg::CfgWidth'($urandom_range(0, 60));
               next_timing[owm_pkg::REG_PRESENCE_TAIL] =
                  owm_pkg::CfgWidth'($urandom_range(0, 60));
            end
            apply_timing();
         end
         pick = $urandom_range(0, 99);
         if (bus_phase == owm_pkg::PH_IDLE) begin
            op = (pick < 12) ? owm_pkg::OP_TICK : 2'($urandom_range(1, 3));
         end else begin
            op = (pick < 4) ? 2'($urandom_range(1, 3)) : owm_pkg::OP_TICK;
         end
         // idle ticks and bounced commands are noise, not counted
         if ((op == owm_pkg::OP_TICK) == (bus_phase != owm_pkg::PH_IDLE)) counted++;
         send_bus_item(op, 8'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= owm_pkg::OP_TICK;
      req_write_value <= '0;
      req_line_level <= 1'b0;
      csr_write_en <= 1'b0;
      csr_index <= owm_pkg::REG_RESET_LOW;
      csr_wdata <= '0;
      timing = owm_pkg::CFG_RESET;
      bus_phase = owm_pkg::PH_IDLE;
      bus_kind = owm_pkg::KIND_NONE;
      slot_count = 0;
      bit_index = 0;
      tx_byte = '0;
      rx_byte = '0;
      presence_seen = 1'b0;
      pulling_low = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_default_timing();
      test_reset_presence();
      test_write_bytes();
      test_read_bytes();
      test_long_durations();
      test_result_backpressure();
      run_random_traffic(200, 0, 0);
      run_random_traffic(160, 62, 0);
      run_random_traffic(160, 0, 62);
      run_random_traffic(160, 19, 19);

      drain_bus_results();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
